[rtl/core/tfc_pkg.sv]
// tfc_pkg: shared constants, types and codes for the 3x3 tent filter.
// No dependencies; used by every module under rtl/core.
package tfc_pkg;

	localparam int MAX_GRID = 1024;
	localparam int ADDR_W   = $clog2(MAX_GRID);
	localparam int GRID_W   = ADDR_W + 1;
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = SAMPLE_W + 5;

	localparam logic [GRID_W-1:0] GRID_MIN   = GRID_W'(2);
	localparam logic [GRID_W-1:0] GRID_MAX   = GRID_W'(MAX_GRID);
	localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(MAX_GRID);

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// column selection and border clamps for one window evaluation
	typedef struct packed {
		logic wrap;       // first column of a row: result is for the previous row's end
		logic left_clamp; // result column is column 0
		logic top_clamp;  // result row is row 0
	} tap_ctl_t;

endpackage

[rtl/core/tfc_line_buf.sv]
// tfc_line_buf: the two row buffers (row above, row middle), one entry per column.
// Registered read on request, one write per cycle. Depends on tfc_pkg.
module tfc_line_buf (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [tfc_pkg::ADDR_W-1:0]  rd_addr,
	output tfc_pkg::sample_t            rd_above,
	output tfc_pkg::sample_t            rd_mid,
	input  logic                        wr_en,
	input  logic [tfc_pkg::ADDR_W-1:0]  wr_addr,
	input  tfc_pkg::sample_t            wr_above,
	input  tfc_pkg::sample_t            wr_mid
);

	tfc_pkg::sample_t above_mem [tfc_pkg::MAX_GRID];
	tfc_pkg::sample_t mid_mem   [tfc_pkg::MAX_GRID];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			above_mem[wr_addr] <= wr_above;
			mid_mem[wr_addr]   <= wr_mid;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_above <= above_mem[rd_addr];
			rd_mid   <= mid_mem[rd_addr];
		end
	end

endmodule

[rtl/core/tfc_kernel.sv]
// tfc_kernel: 3x3 window columns and the weighted tent sum with rounding.
// Shifts in a new column on step. Depends on tfc_pkg.
module tfc_kernel (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  tfc_pkg::sample_t     col_top,
	input  tfc_pkg::sample_t     col_mid,
	input  tfc_pkg::sample_t     col_bot,
	input  tfc_pkg::tap_ctl_t    ctl,
	output tfc_pkg::sample_t     filtered
);

	// [row][0] = left column, [row][1] = centre column of the stored window
	tfc_pkg::sample_t win_q [3][2];
	tfc_pkg::sample_t new_col [3];
	tfc_pkg::sample_t l [3];
	tfc_pkg::sample_t c [3];
	tfc_pkg::sample_t r [3];
	logic signed [tfc_pkg::SUM_W-1:0] sum;
	logic signed [tfc_pkg::SUM_W-1:0] rounded;

	assign new_col[0] = col_top;
	assign new_col[1] = col_mid;
	assign new_col[2] = col_bot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= '0;
				win_q[k][1] <= '0;
			end
		end else if (step) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= new_col[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ctl.wrap) begin
				l[k] = win_q[k][0];
				c[k] = win_q[k][1];
				r[k] = win_q[k][1];
			end else begin
				l[k] = ctl.left_clamp ? win_q[k][1] : win_q[k][0];
				c[k] = win_q[k][1];
				r[k] = new_col[k];
			end
		end
		if (ctl.top_clamp) begin
			l[0] = l[1];
			c[0] = c[1];
			r[0] = r[1];
		end
	end

	always_comb begin
		sum = (tfc_pkg::SUM_W'(c[1]) <<< 2)
			+ ((tfc_pkg::SUM_W'(l[1]) + tfc_pkg::SUM_W'(r[1])
			  + tfc_pkg::SUM_W'(c[0]) + tfc_pkg::SUM_W'(c[2])) <<< 1)
			+ tfc_pkg::SUM_W'(l[0]) + tfc_pkg::SUM_W'(r[0])
			+ tfc_pkg::SUM_W'(l[2]) + tfc_pkg::SUM_W'(r[2]);
		rounded = (sum + tfc_pkg::SUM_W'(8)) >>> 4;
	end

	assign filtered = rounded[tfc_pkg::SAMPLE_W-1:0];

endmodule

[rtl/core/tent_filter_3x3_clamped.sv]
// tent_filter_3x3_clamped: streaming 3x3 binomial blur with clamped borders.
// Uses tfc_pkg, tfc_line_buf and tfc_kernel.
//
// channel   | dir | handshake         | payload
// s_*       | in  | s_tvalid/s_tready | s_tdata = sample, s_tuser = opcode
// m_*       | out | m_tvalid/m_tready | m_tdata = filtered, m_tlast = end_of_row,
//           |     |                   | m_tuser = end_of_frame
// cfg_*     | in  | cfg_wr_en         | cfg_wr_data = grid_size
//
// One request per cycle while s1 is free or advancing. A request is read from the
// row buffers when accepted into stage s1; its result enters the output register
// when s1 advances. Results lag the input stream by grid_size+1 requests, then
// grid_size+1 flush requests drain a frame. m_tready low with m_tvalid high holds
// both stages. Reset clears control state; row buffer contents stay unknown.
module tent_filter_3x3_clamped (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tfc_pkg::SAMPLE_W-1:0]   s_tdata,  // [15:0] sample
	input  logic                           s_tuser,  // [0] opcode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tfc_pkg::SAMPLE_W-1:0]   m_tdata,  // [15:0] filtered
	output logic                           m_tlast,
	output logic                           m_tuser,  // [0] end_of_frame
	input  logic                           cfg_wr_en,
	input  logic [tfc_pkg::GRID_W-1:0]     cfg_wr_data
);

	localparam int AW = tfc_pkg::ADDR_W;
	localparam int GW = tfc_pkg::GRID_W;

	logic [GW-1:0]  grid_q;
	logic [AW-1:0]  col_q;
	logic [AW-1:0]  row_q;
	logic [GW-1:0]  pend_q;
	logic [GW-1:0]  n;

	logic             accept;
	logic             enter;
	logic [AW-1:0]    xi;
	logic [GW-1:0]    zi;
	logic             emit;
	logic [GW-1:0]    k;
	logic [GW-1:0]    xi_next;
	logic [GW-1:0]    zi_next;
	tfc_pkg::opcode_t op;
	tfc_pkg::tap_ctl_t ctl;
	logic             eor;
	logic             eof;

	logic              valid_s1;
	logic [AW-1:0]     xi_s1;
	logic              flush_s1;
	logic              emit_s1;
	tfc_pkg::tap_ctl_t ctl_s1;
	logic              eor_s1;
	logic              eof_s1;
	tfc_pkg::sample_t  sample_s1;
	logic              fwd_s1;
	tfc_pkg::sample_t  fwd_above_s1;
	tfc_pkg::sample_t  fwd_mid_s1;

	tfc_pkg::sample_t  raw_above;
	tfc_pkg::sample_t  raw_mid;
	tfc_pkg::sample_t  above_rd;
	tfc_pkg::sample_t  mid_rd;
	tfc_pkg::sample_t  bot_val;
	tfc_pkg::sample_t  filtered;
	logic              adv1;
	logic              out_valid_q;

	assign op = tfc_pkg::opcode_t'(s_tuser);

	always_comb begin
		if (grid_q < tfc_pkg::GRID_MIN) begin
			n = tfc_pkg::GRID_MIN;
		end else if (grid_q > tfc_pkg::GRID_MAX) begin
			n = tfc_pkg::GRID_MAX;
		end else begin
			n = grid_q;
		end
	end

	assign adv1     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv1;
	assign accept   = s_tvalid && s_tready;

	// request decode: position, emit and clamp flags
	always_comb begin
		xi    = '0;
		zi    = '0;
		emit  = 1'b0;
		enter = 1'b0;
		k     = n + GW'(1) - pend_q;
		unique case (op)
			tfc_pkg::OP_PIXEL: begin
				enter = 1'b1;
				if ({1'b0, col_q} < n && {1'b0, row_q} < n) begin
					xi = col_q;
					zi = {1'b0, row_q};
				end
				emit = (zi >= GW'(2)) || (zi == GW'(1) && xi != '0);
			end
			tfc_pkg::OP_FLUSH: begin
				if (pend_q != '0 && pend_q <= n + GW'(1)) begin
					enter = 1'b1;
					emit  = 1'b1;
					if (k == n) begin
						xi = '0;
						zi = n + GW'(1);
					end else begin
						xi = k[AW-1:0];
						zi = n;
					end
				end
			end
			default: ;
		endcase
		ctl.wrap       = (xi == '0);
		ctl.left_clamp = (xi == AW'(1));
		ctl.top_clamp  = ctl.wrap ? (zi == GW'(2)) : (zi == GW'(1));
		eor            = ctl.wrap;
		eof            = ctl.wrap && ({1'b0, zi} == {1'b0, n} + (GW+1)'(1));
		xi_next        = {1'b0, xi} + GW'(1);
		zi_next        = zi + GW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= tfc_pkg::GRID_RESET;
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (cfg_wr_en) begin
			grid_q <= cfg_wr_data;
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (accept) begin
			if (op == tfc_pkg::OP_PIXEL) begin
				pend_q <= '0;
				if (xi_next < n) begin
					col_q <= xi_next[AW-1:0];
					row_q <= zi[AW-1:0];
				end else begin
					col_q <= '0;
					if (zi_next < n) begin
						row_q <= zi_next[AW-1:0];
					end else begin
						row_q  <= '0;
						pend_q <= n + GW'(1);
					end
				end
			end else if (enter) begin
				pend_q <= pend_q - GW'(1);
			end else begin
				pend_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= enter;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage s1 request fields, and the write-to-read bypass when the request ahead writes the column being read
	always_ff @(posedge clk) begin
		if (accept && enter) begin
			xi_s1        <= xi;
			flush_s1     <= (op == tfc_pkg::OP_FLUSH);
			emit_s1      <= emit;
			ctl_s1       <= ctl;
			eor_s1       <= eor;
			eof_s1       <= eof;
			sample_s1    <= tfc_pkg::sample_t'(s_tdata);
			fwd_s1       <= valid_s1 && (xi_s1 == xi);
			fwd_above_s1 <= mid_rd;
			fwd_mid_s1   <= bot_val;
		end
	end

	tfc_line_buf u_line_buf (
		.clk      (clk),
		.rd_en    (accept && enter),
		.rd_addr  (xi),
		.rd_above (raw_above),
		.rd_mid   (raw_mid),
		.wr_en    (adv1),
		.wr_addr  (xi_s1),
		.wr_above (mid_rd),
		.wr_mid   (bot_val)
	);

	assign above_rd = fwd_s1 ? fwd_above_s1 : raw_above;
	assign mid_rd   = fwd_s1 ? fwd_mid_s1 : raw_mid;
	assign bot_val  = flush_s1 ? mid_rd : sample_s1;

	tfc_kernel u_kernel (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv1),
		.col_top  (above_rd),
		.col_mid  (mid_rd),
		.col_bot  (bot_val),
		.ctl      (ctl_s1),
		.filtered (filtered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && emit_s1) begin
			m_tdata <= filtered;
			m_tlast <= eor_s1;
			m_tuser <= eof_s1;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

[tb/sv/testbench.sv]
// testbench: self-checking bench for tent_filter_3x3_clamped, the 3x3 binomial blur.
// Drives directed and random raster frames with flush requests, predicts every
// filtered sample, row end and frame end. Depends on tfc_pkg and the RTL only.
module testbench;
	import tfc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned RAND_ITEMS  = 360;

	typedef struct {
		opcode_t op;
		sample_t value;
	} request_t;

	typedef struct {
		sample_t filtered;
		logic    row_end;
		logic    frame_end;
	} blurred_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                s_tvalid    = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata     = '0;
	logic                s_tuser     = 1'b0;
	logic                m_tvalid;
	logic                m_tready    = 1'b0;
	logic [SAMPLE_W-1:0] m_tdata;
	logic                m_tlast;
	logic                m_tuser;
	logic                cfg_wr_en   = 1'b0;
	logic [GRID_W-1:0]   cfg_wr_data = '0;

	tent_filter_3x3_clamped u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	request_t    req_q[$];
	blurred_t    blurred_q[$];
	int unsigned n_issued   = 0;
	int unsigned n_accepted = 0;
	int unsigned src_gap    = 0;
	int unsigned snk_gap    = 0;
	bit          idle_on    = 1'b1;
	int unsigned errors     = 0;
	int unsigned cycles     = 0;
	int unsigned rand_made  = 0;

	// shadow of the filter state
	sample_t           above_mem [MAX_GRID];
	sample_t           mid_mem   [MAX_GRID];
	sample_t           win       [3][3];
	int unsigned       col_pos   = 0;
	int unsigned       row_pos   = 0;
	int unsigned       drain_left = 0;
	logic [GRID_W-1:0] grid_reg  = GRID_RESET;

	initial begin
		foreach (above_mem[i]) begin
			above_mem[i] = '0;
			mid_mem[i]   = '0;
		end
		foreach (win[i, j])
			win[i][j] = '0;
	end

	function automatic int unsigned grid_span();
		if (grid_reg < GRID_MIN)
			return 32'(GRID_MIN);
		if (grid_reg > GRID_MAX)
			return 32'(GRID_MAX);
		return 32'(grid_reg);
	endfunction

	// shift one pixel (real or drain copy) into the window; blur the window if asked
	function automatic void shift_window(int unsigned n, int unsigned xi, int unsigned zi,
			sample_t v, bit emit);
		sample_t  pre[3][3];
		int       l[3], c[3], r[3];
		int unsigned xc, zc;
		int       acc;
		blurred_t res;
		pre = win;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2]     = above_mem[xi];
		win[1][2]     = mid_mem[xi];
		win[2][2]     = v;
		above_mem[xi] = mid_mem[xi];
		mid_mem[xi]   = v;
		if (!emit)
			return;
		for (int k = 0; k < 3; k++) begin
			if (xi == 0) begin
				l[k] = pre[k][1];
				c[k] = pre[k][2];
				r[k] = pre[k][2];
			end else begin
				l[k] = win[k][0];
				c[k] = win[k][1];
				r[k] = win[k][2];
			end
		end
		if (xi == 0) begin
			// row wrap: result belongs to the last column of the previous row
			xc = n - 1;
			zc = zi - 2;
		end else begin
			xc = xi - 1;
			zc = zi - 1;
			if (xc == 0)
				for (int k = 0; k < 3; k++)
					l[k] = c[k];
		end
		if (zc == 0) begin
			l[0] = l[1];
			c[0] = c[1];
			r[0] = r[1];
		end
		acc = 4 * c[1] + 2 * (l[1] + r[1] + c[0] + c[2]) + l[0] + r[0] + l[2] + r[2];
		res.filtered  = sample_t'((acc + 8) >>> 4);
		res.row_end   = (xc == n - 1);
		res.frame_end = (xc == n - 1) && (zc == n - 1);
		blurred_q.push_back(res);
	endfunction

	function automatic void predict_request(opcode_t op, sample_t v);
		int unsigned n, xi, zi, k;
		n = grid_span();
		if (op == OP_PIXEL) begin
			drain_left = 0;
			if (col_pos >= n || row_pos >= n) begin
				col_pos = 0;
				row_pos = 0;
			end
			xi = col_pos;
			zi = row_pos;
			shift_window(n, xi, zi, v, (zi >= 2) || (zi == 1 && xi >= 1));
			if (xi + 1 < n) begin
				col_pos = xi + 1;
			end else begin
				col_pos = 0;
				if (zi + 1 < n) begin
					row_pos = zi + 1;
				end else begin
					row_pos    = 0;
					drain_left = n + 1;
				end
			end
			return;
		end
		if (drain_left == 0 || drain_left > n + 1) begin
			drain_left = 0;
			return;
		end
		k = n + 1 - drain_left;
		if (k == n) begin
			xi = 0;
			zi = n + 1;
		end else begin
			xi = k;
			zi = n;
		end
		// row below the grid is a copy of the last row
		shift_window(n, xi, zi, mid_mem[xi], 1'b1);
		drain_left--;
	endfunction

	function automatic void write_shadow_grid(logic [GRID_W-1:0] v);
		grid_reg   = v;
		col_pos    = 0;
		row_pos    = 0;
		drain_left = 0;
	endfunction

	// driver: requests and sink stalls change on the falling edge
	always @(negedge clk) begin
		request_t nxt_req;
		if (arst_n) begin
			if (!s_tvalid || n_accepted == n_issued) begin
				if (src_gap != 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (req_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 4) == 0) begin
					src_gap = $urandom_range(0, 3);
					s_tvalid <= 1'b0;
				end else begin
					nxt_req = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt_req.value;
					s_tuser  <= nxt_req.op;
					n_issued++;
				end
			end
			if (snk_gap != 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				snk_gap = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: results checked, config and requests fed to the shadow model
	always @(posedge clk) begin
		blurred_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (blurred_q.size() == 0) begin
					errors++;
					if (errors < 100)
						$display("%0t: unexpected result got %h last %b user %b",
							$time, m_tdata, m_tlast, m_tuser);
				end else begin
					want = blurred_q.pop_front();
					if (m_tdata !== want.filtered || m_tlast !== want.row_end ||
							m_tuser !== want.frame_end) begin
						errors++;
						if (errors < 100)
							$display("%0t: mismatch exp %h/%b/%b got %h/%b/%b", $time,
								want.filtered, want.row_end, want.frame_end,
								m_tdata, m_tlast, m_tuser);
					end
				end
			end
			if (cfg_wr_en)
				write_shadow_grid(cfg_wr_data);
			if (s_tvalid && s_tready) begin
				predict_request(opcode_t'(s_tuser), sample_t'(s_tdata));
				n_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_req(opcode_t op, sample_t v);
		request_t rq;
		rq.op    = op;
		rq.value = v;
		req_q.push_back(rq);
	endtask

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return '0;
			3:       return 16'shFFFF;
			default: return sample_t'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (req_q.size() != 0 || n_issued != n_accepted || blurred_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_grid(logic [GRID_W-1:0] v);
		cfg_wr_data = v;
		cfg_wr_en   = 1'b1;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	// one frame, mostly well formed; some with stray flushes, truncation or odd drains
	task automatic gen_frame(int unsigned n);
		int unsigned npix, nflush, style;
		style = $urandom_range(0, 9);
		npix  = n * n;
		if (style == 1)
			npix = npix - $urandom_range(1, n);
		nflush = n + 1;
		if (style == 2)
			nflush = $urandom_range(0, n);
		else if (style == 3)
			nflush = n + 1 + $urandom_range(1, 3);
		for (int unsigned i = 0; i < npix; i++) begin
			if (style == 0 && $urandom_range(0, 15) == 0)
				add_req(OP_FLUSH, rand_sample());
			add_req(OP_PIXEL, rand_sample());
		end
		for (int unsigned i = 0; i < nflush; i++)
			add_req(OP_FLUSH, rand_sample());
		rand_made += npix + ((nflush > n + 1) ? n + 1 : nflush);
	endtask

	initial begin
		logic [GRID_W-1:0] gsel;
		int unsigned       r, eff;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// smallest grid: extremes, stray flush, mid-frame flush, abandoned drain
		write_grid('0);
		add_req(OP_FLUSH, 16'sh7FFF);
		add_req(OP_PIXEL, 16'sh7FFF);
		add_req(OP_PIXEL, 16'sh8000);
		add_req(OP_FLUSH, 16'sh0000);
		add_req(OP_PIXEL, 16'sh8000);
		add_req(OP_PIXEL, 16'sh7FFF);
		add_req(OP_FLUSH, 16'shFFFF);
		add_req(OP_FLUSH, 16'sh0000);
		add_req(OP_PIXEL, 16'sh0000);
		add_req(OP_PIXEL, 16'shFFFF);
		add_req(OP_PIXEL, 16'sh7FFF);
		add_req(OP_PIXEL, 16'sh8000);
		repeat (4) add_req(OP_FLUSH, 16'sh5A5A);
		add_req(OP_PIXEL, 16'sh7FFF);
		add_req(OP_PIXEL, 16'sh7FFF);
		add_req(OP_PIXEL, 16'sh7FFF);
		add_req(OP_PIXEL, 16'sh7FFF);
		repeat (3) add_req(OP_FLUSH, 16'sh0000);
		wait_idle();

		// oversized value saturates to the largest grid; just past the first row
		write_grid('1);
		for (int i = 0; i < MAX_GRID + 4; i++)
			add_req(OP_PIXEL, rand_sample());
		wait_idle();

		while (rand_made < RAND_ITEMS) begin
			idle_on = (rand_made > RAND_ITEMS - 100) ? 1'b0 : ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 19);
			case (r)
				0:       gsel = '0;
				1:       gsel = GRID_W'(1);
				2, 3:    gsel = GRID_W'($urandom_range(9, 14));
				default: gsel = GRID_W'($urandom_range(2, 8));
			endcase
			write_grid(gsel);
			eff = grid_span();
			repeat ($urandom_range(1, 3)) gen_frame(eff);
			wait_idle();
		end

		wait_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
